/* rtl/core/hbp_pkg.sv */
// Shared types, codes and helpers for the hybrid branch predictor.
// No dependencies; imported by every module of the block except hbp_ram.
package hbp_pkg;

  typedef enum logic [1:0] {
    MODE_BIMODAL = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_HYBRID  = 2'd2
  } mode_t;

  localparam logic [2:0] REG_MODE          = 3'd0;
  localparam logic [2:0] REG_BIMODAL_BITS  = 3'd1;
  localparam logic [2:0] REG_GSHARE_BITS   = 3'd2;
  localparam logic [2:0] REG_HISTORY_BITS  = 3'd3;
  localparam logic [2:0] REG_CHOOSER_BITS  = 3'd4;
  localparam logic [2:0] REG_BTB_ENABLE    = 3'd5;
  localparam logic [2:0] REG_BTB_SET_BITS  = 3'd6;
  localparam logic [2:0] REG_BTB_WAYS      = 3'd7;

  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
  localparam logic [1:0] CHOOSER_INIT   = 2'd1;

  typedef struct packed {
    logic       enable;
    logic [3:0] set_bits;
    logic [3:0] ways;
  } btb_cfg_t;

  typedef struct packed {
    logic pred;
    logic mispred;
    logic hit;
    logic use_g;
  } res_t;

  // 2-bit saturating counter step toward the outcome
  function automatic logic [1:0] train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

/* rtl/core/hbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbp_ram #(
  parameter int W = 2,
  parameter int D = 4096
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic                              re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/hbp_btb.sv */
// Set-associative LRU branch target buffer, one row of ways per set.
// Depends on hbp_pkg and hbp_ram.
module hbp_btb #(
  parameter int OFFSET_BITS  = 2,
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             acc,
  input  logic [31:0]      rd_pc,
  input  logic             s1_vld,
  input  logic [31:0]      s1_pc,
  input  hbp_pkg::btb_cfg_t cfg,
  input  logic             flush,
  output logic             hit
);
  import hbp_pkg::*;

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int TAG_W  = 32 - OFFSET_BITS;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [MAX_WAYS-1:0]            vld;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  logic [3:0]        sb;
  logic [4:0]        w;
  logic [SET_IW-1:0] set_mask, rd_set, s1_set;
  logic [TAG_W-1:0]  tag;
  row_t              ram_q, cur, nxt, byp_row_r;
  logic [SETS-1:0]   rowv_r;
  logic              rowv_q_r, byp_r, we, btb_hit;
  logic [AGE_W-1:0]  hw, victim, maxa;

  always_comb begin
    sb = (cfg.set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : cfg.set_bits;
    if (cfg.ways == 4'd0) w = 5'd1;
    else if ({1'b0, cfg.ways} > 5'(MAX_WAYS)) w = 5'(MAX_WAYS);
    else w = {1'b0, cfg.ways};
  end

  assign set_mask = SET_IW'((32'd1 << sb) - 32'd1);
  assign rd_set   = rd_pc[OFFSET_BITS +: SET_IW] & set_mask;
  assign s1_set   = s1_pc[OFFSET_BITS +: SET_IW] & set_mask;
  assign tag      = TAG_W'(s1_pc[31:OFFSET_BITS] >> sb);
  assign we       = adv && s1_vld && cfg.enable;

  hbp_ram #(.W($bits(row_t)), .D(SETS)) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (s1_set),
    .wdata (nxt),
    .re    (adv),
    .raddr (rd_set),
    .rdata (ram_q)
  );

  always_comb begin
    cur = byp_r ? byp_row_r : ram_q;
    // an untouched row reads as freshly flushed
    if (!(byp_r || rowv_q_r)) begin
      cur.vld = '0;
      for (int j = 0; j < MAX_WAYS; j++)
        cur.age[j] = (5'(j) < w) ? AGE_W'(int'(w) - 1 - j) : '0;
    end
    btb_hit = 1'b0;
    hw      = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (5'(j) < w && cur.vld[j] && cur.tag[j] == tag) begin
        btb_hit = 1'b1;
        hw      = AGE_W'(j);
      end
    end
    victim = '0;
    maxa   = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (5'(j) < w && cur.age[j] >= maxa) begin
        maxa   = cur.age[j];
        victim = AGE_W'(j);
      end
    end
    nxt = cur;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (5'(k) < w) begin
        if (!btb_hit || cur.age[k] < cur.age[hw]) nxt.age[k] = cur.age[k] + AGE_W'(1);
      end
    end
    if (btb_hit) begin
      nxt.age[hw] = '0;
    end else begin
      nxt.tag[victim] = tag;
      nxt.vld[victim] = 1'b1;
      nxt.age[victim] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r   <= '0;
      rowv_q_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (flush) rowv_r <= '0;
      else if (we) rowv_r[s1_set] <= 1'b1;
      if (adv) begin
        rowv_q_r <= rowv_r[rd_set];
        // the row written at this edge is not yet in the RAM read data
        byp_r    <= we && acc && (rd_set == s1_set);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) byp_row_r <= nxt;
  end

  assign hit = !cfg.enable || btb_hit;

endmodule

/* rtl/core/hbp_pht.sv */
// Bimodal, gshare and chooser counter tables with the prediction stage.
// Depends on hbp_pkg and hbp_ram.
module hbp_pht #(
  parameter int MAX_TABLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      s1_vld,
  input  logic                      s1_hit,
  input  logic                      s1_taken,
  input  logic [1:0]                mode,
  input  logic [MAX_TABLE_BITS-1:0] bi,
  input  logic [MAX_TABLE_BITS-1:0] gi,
  input  logic [MAX_TABLE_BITS-1:0] ci,
  output logic                      s2_vld,
  output hbp_pkg::res_t             res,
  output logic                      busy
);
  import hbp_pkg::*;

  localparam int TI = MAX_TABLE_BITS;

  logic          s2_vld_r, s2_hit_r, s2_taken_r;
  logic [1:0]    s2_mode_r;
  logic [TI-1:0] s2_bi_r, s2_gi_r, s2_ci_r;
  logic [TI:0]   clr_r;
  logic          byp_b_r, byp_g_r, byp_c_r;
  logic [1:0]    vb_r, vg_r, vc_r;
  logic [1:0]    qb, qg, qc, cb, cg, cc, nb, ng, nc;
  logic          pred, use_g, wb, wg, wc, c_up, upd_b, upd_g, upd_c, rb, rg;

  assign busy = !clr_r[TI];

  hbp_ram #(.W(2), .D(1 << TI)) u_bim (
    .clk(clk), .we(busy || upd_b), .waddr(busy ? clr_r[TI-1:0] : s2_bi_r),
    .wdata(busy ? CTR_WEAK_TAKEN : nb), .re(adv), .raddr(bi), .rdata(qb));

  hbp_ram #(.W(2), .D(1 << TI)) u_gsh (
    .clk(clk), .we(busy || upd_g), .waddr(busy ? clr_r[TI-1:0] : s2_gi_r),
    .wdata(busy ? CTR_WEAK_TAKEN : ng), .re(adv), .raddr(gi), .rdata(qg));

  hbp_ram #(.W(2), .D(1 << TI)) u_cho (
    .clk(clk), .we(busy || upd_c), .waddr(busy ? clr_r[TI-1:0] : s2_ci_r),
    .wdata(busy ? CHOOSER_INIT : nc), .re(adv), .raddr(ci), .rdata(qc));

  always_comb begin
    cb = byp_b_r ? vb_r : qb;
    cg = byp_g_r ? vg_r : qg;
    cc = byp_c_r ? vc_r : qc;
    rb = (cb[1] == s2_taken_r);
    rg = (cg[1] == s2_taken_r);
    wb = 1'b0;
    wg = 1'b0;
    wc = 1'b0;
    c_up = rg;
    case (s2_mode_r)
      MODE_GSHARE: begin
        use_g = 1'b1;
        wg    = 1'b1;
      end
      MODE_HYBRID: begin
        use_g = cc[1];
        wg    = cc[1];
        wb    = !cc[1];
        wc    = rb ^ rg;
      end
      default: begin
        use_g = 1'b0;
        wb    = 1'b1;
      end
    endcase
    pred = use_g ? cg[1] : cb[1];
    nb = train(cb, s2_taken_r);
    ng = train(cg, s2_taken_r);
    nc = train(cc, c_up);
    upd_b = adv && s2_vld_r && s2_hit_r && wb;
    upd_g = adv && s2_vld_r && s2_hit_r && wg;
    upd_c = adv && s2_vld_r && s2_hit_r && wc;
    res.pred    = s2_hit_r && pred;
    res.use_g   = s2_hit_r && use_g;
    res.hit     = s2_hit_r;
    res.mispred = (s2_hit_r && pred) != s2_taken_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      s2_vld_r <= 1'b0;
      byp_b_r  <= 1'b0;
      byp_g_r  <= 1'b0;
      byp_c_r  <= 1'b0;
    end else begin
      if (busy) clr_r <= clr_r + (TI+1)'(1);
      if (adv) begin
        s2_vld_r <= s1_vld;
        // forward counters written at the same edge as the new read
        byp_b_r  <= upd_b && (s2_bi_r == bi);
        byp_g_r  <= upd_g && (s2_gi_r == gi);
        byp_c_r  <= upd_c && (s2_ci_r == ci);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hit_r   <= s1_hit;
      s2_taken_r <= s1_taken;
      s2_mode_r  <= mode;
      s2_bi_r    <= bi;
      s2_gi_r    <= gi;
      s2_ci_r    <= ci;
      vb_r       <= nb;
      vg_r       <= ng;
      vc_r       <= nc;
    end
  end

  assign s2_vld = s2_vld_r;

endmodule

/* rtl/core/hybrid_branch_predictor_btb.sv */
// Hybrid bimodal/gshare/tournament branch predictor with optional BTB.
// Depends on hbp_pkg, hbp_btb and hbp_pht.
//
// Usage: each input item is one resolved branch (in_branch_pc,
// in_actual_taken), accepted when in_valid is high and in_stall low. Each item
// gives one result item (prediction, misprediction flag, BTB hit, table used)
// on the out_ channel, accepted when out_valid is high and out_stall low.
// Throughput is one item per cycle while the pipeline is not held; the BTB
// row is looked up first, the counter tables are read next, and the result
// register then loads, raising out_valid.
// Back-to-back updates to the same counter or BTB row are forwarded around
// the RAMs.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle; writing a BTB register flushes the BTB at once.
// Reset: rst_n low restores register defaults, clears the history and BTB
// row flags, then a clearing pass over all 2**MAX_TABLE_BITS entries (4096 by
// default) loads the counter tables; in_stall stays high during that pass.
// When out_stall holds a result, the whole pipeline holds and in_stall rises.
module hybrid_branch_predictor_btb #(
  parameter int MAX_TABLE_BITS = 12,
  parameter int OFFSET_BITS    = 2,
  parameter int MAX_SET_BITS   = 8,
  parameter int MAX_WAYS       = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_branch_pc,
  input  logic        in_actual_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_predicted_taken,
  output logic        out_mispredicted,
  output logic        out_btb_hit,
  output logic        out_chose_gshare,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import hbp_pkg::*;

  localparam int TI = MAX_TABLE_BITS;

  function automatic logic [4:0] clamp_tb(input logic [3:0] v);
    logic [4:0] r;
    r = {1'b0, v};
    if (v == 4'd0) r = 5'd1;
    else if (r > 5'(MAX_TABLE_BITS)) r = 5'(MAX_TABLE_BITS);
    return r;
  endfunction

  function automatic logic [TI-1:0] mask_of(input logic [4:0] m);
    return TI'((32'd1 << m) - 32'd1);
  endfunction

  logic [1:0]    mode_r;
  logic [3:0]    bim_bits_r, gsh_bits_r, hist_bits_r, cho_bits_r, btb_sets_r, btb_ways_r;
  logic          btb_en_r, flush;
  btb_cfg_t      btb_cfg;
  logic          adv, acc, busy, s2_vld, s1_hit, hist_we;
  logic          s1_vld_r, s1_taken_r;
  logic [31:0]   s1_pc_r;
  logic [TI-1:0] hist_r, hist, hist_nxt, pcw, bi, gi, ci;
  logic [4:0]    mb, mg, mk, n;
  res_t          res;
  logic          out_valid_r;
  res_t          out_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || busy;
  assign acc      = in_valid && !in_stall;
  assign flush    = cfg_we && (cfg_index == REG_BTB_ENABLE || cfg_index == REG_BTB_SET_BITS
                    || cfg_index == REG_BTB_WAYS);
  assign btb_cfg  = '{enable: btb_en_r, set_bits: btb_sets_r, ways: btb_ways_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BIMODAL;
      bim_bits_r  <= 4'd12;
      gsh_bits_r  <= 4'd12;
      hist_bits_r <= 4'd8;
      cho_bits_r  <= 4'd8;
      btb_en_r    <= 1'b0;
      btb_sets_r  <= 4'd0;
      btb_ways_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode_r      <= cfg_wdata[1:0];
        REG_BIMODAL_BITS: bim_bits_r  <= cfg_wdata;
        REG_GSHARE_BITS:  gsh_bits_r  <= cfg_wdata;
        REG_HISTORY_BITS: hist_bits_r <= cfg_wdata;
        REG_CHOOSER_BITS: cho_bits_r  <= cfg_wdata;
        REG_BTB_ENABLE:   btb_en_r    <= cfg_wdata[0];
        REG_BTB_SET_BITS: btb_sets_r  <= cfg_wdata;
        REG_BTB_WAYS:     btb_ways_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mb   = clamp_tb(bim_bits_r);
    mg   = clamp_tb(gsh_bits_r);
    mk   = clamp_tb(cho_bits_r);
    n    = ({1'b0, hist_bits_r} > mg) ? mg : {1'b0, hist_bits_r};
    pcw  = s1_pc_r[OFFSET_BITS +: TI];
    hist = hist_r & mask_of(n);
    bi   = pcw & mask_of(mb);
    ci   = pcw & mask_of(mk);
    // history folds into the top n bits of the gshare index
    gi   = (pcw & mask_of(mg)) ^ (hist << (mg - n));
    hist_nxt = (hist >> 1) | (TI'(s1_taken_r) << (n - 5'd1));
    hist_we  = adv && s1_vld_r && s1_hit && n != 5'd0
               && (mode_r == MODE_GSHARE || mode_r == MODE_HYBRID);
  end

  hbp_btb #(
    .OFFSET_BITS(OFFSET_BITS), .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)
  ) u_btb (
    .clk(clk), .rst_n(rst_n), .adv(adv), .acc(acc), .rd_pc(in_branch_pc),
    .s1_vld(s1_vld_r), .s1_pc(s1_pc_r), .cfg(btb_cfg), .flush(flush), .hit(s1_hit)
  );

  hbp_pht #(.MAX_TABLE_BITS(MAX_TABLE_BITS)) u_pht (
    .clk(clk), .rst_n(rst_n), .adv(adv), .s1_vld(s1_vld_r), .s1_hit(s1_hit),
    .s1_taken(s1_taken_r), .mode(mode_r), .bi(bi), .gi(gi), .ci(ci),
    .s2_vld(s2_vld), .res(res), .busy(busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
    end else begin
      if (hist_we) hist_r <= hist_nxt;
      if (adv) begin
        s1_vld_r    <= acc;
        out_valid_r <= s2_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pc_r    <= in_branch_pc;
      s1_taken_r <= in_actual_taken;
      out_r      <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_r.pred;
  assign out_mispredicted    = out_r.mispred;
  assign out_btb_hit         = out_r.hit;
  assign out_chose_gshare    = out_r.use_g;

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("counter clearing pass not started after reset");
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("item accepted during clearing pass");
  a_miss_predicts_nt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_btb_hit |-> !out_predicted_taken && !out_chose_gshare)
    else $error("BTB miss produced a taken or gshare prediction");
  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_vld_r)
    else $error("accepted item lost before first stage");

endmodule

/* tb/tb_hybrid_branch_predictor_btb.sv */
// Self-checking testbench for hybrid_branch_predictor_btb.
// Predicts each branch outcome with its own counter tables and BTB model,
// drives directed and random branch streams and register settings; needs hbp_pkg.
`timescale 1ns / 1ps

import hbp_pkg::*;

class branch_scoreboard;
  logic [1:0] bim_ctr[4096];
  logic [1:0] gsh_ctr[4096];
  logic [1:0] cho_ctr[4096];
  logic [11:0] ghist;
  logic [29:0] tags[256][8];
  bit          vld[256][8];
  int unsigned age[256][8];
  logic [1:0] mode;
  logic [3:0] bim_bits, gsh_bits, hist_bits, cho_bits, set_bits, ways;
  bit         btb_on;
  res_t       pending[$];
  int         errors;

  function new();
    for (int i = 0; i < 4096; i++) begin
      bim_ctr[i] = CTR_WEAK_TAKEN;
      gsh_ctr[i] = CTR_WEAK_TAKEN;
      cho_ctr[i] = CHOOSER_INIT;
    end
    ghist = '0;
    mode = MODE_BIMODAL;
    bim_bits = 4'd12; gsh_bits = 4'd12; hist_bits = 4'd8; cho_bits = 4'd8;
    btb_on = 0; set_bits = 4'd0; ways = 4'd1;
    errors = 0;
    flush_btb();
  endfunction

  function int unsigned clamp_tbl(logic [3:0] b);
    return (b < 1) ? 1 : (b > 12) ? 12 : b;
  endfunction

  function int unsigned eff_ways();
    return (ways < 1) ? 1 : (ways > 8) ? 8 : ways;
  endfunction

  function int unsigned eff_sets();
    return (set_bits > 8) ? 8 : set_bits;
  endfunction

  function void flush_btb();
    int unsigned w;
    w = eff_ways();
    for (int s = 0; s < 256; s++)
      for (int j = 0; j < 8; j++) begin
        vld[s][j] = 0;
        tags[s][j] = '0;
        age[s][j] = (j < w) ? w - 1 - j : 0;
      end
  endfunction

  function void write_reg(logic [2:0] idx, logic [3:0] v);
    case (idx)
      REG_MODE:         mode = v[1:0];
      REG_BIMODAL_BITS: bim_bits = v;
      REG_GSHARE_BITS:  gsh_bits = v;
      REG_HISTORY_BITS: hist_bits = v;
      REG_CHOOSER_BITS: cho_bits = v;
      REG_BTB_ENABLE:   begin btb_on = v[0]; flush_btb(); end
      REG_BTB_SET_BITS: begin set_bits = v; flush_btb(); end
      REG_BTB_WAYS:     begin ways = v; flush_btb(); end
      default: ;
    endcase
  endfunction

  function logic [1:0] step_ctr(logic [1:0] c, bit up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  function bit btb_access(logic [31:0] pc);
    int unsigned sb, w, set, victim, maxage, r;
    logic [31:0] tag;
    sb = eff_sets();
    w = eff_ways();
    set = (pc >> 2) & ((1 << sb) - 1);
    tag = pc >> (2 + sb);
    for (int j = 0; j < w; j++)
      if (vld[set][j] && tags[set][j] == tag[29:0]) begin
        r = age[set][j];
        for (int k = 0; k < w; k++)
          if (age[set][k] < r) age[set][k]++;
        age[set][j] = 0;
        return 1;
      end
    victim = 0;
    maxage = 0;
    for (int j = 0; j < w; j++)
      if (age[set][j] >= maxage) begin
        maxage = age[set][j];
        victim = j;
      end
    for (int j = 0; j < w; j++)
      if (age[set][j] < 255) age[set][j]++;
    tags[set][victim] = tag[29:0];
    vld[set][victim] = 1;
    age[set][victim] = 0;
    return 0;
  endfunction

  // Predict and train for one accepted branch.
  function void note_branch(logic [31:0] pc, bit taken);
    int unsigned mb, mg, mk, n, lowb, bi, gpc, gi, ci, hist;
    logic [31:0] pcw;
    bit hit, pred, use_g, pb, pg, rb, rg;
    res_t r;
    pcw = pc >> 2;
    mb = clamp_tbl(bim_bits);
    mg = clamp_tbl(gsh_bits);
    mk = clamp_tbl(cho_bits);
    n = (hist_bits > mg) ? mg : hist_bits;
    bi = pcw & ((1 << mb) - 1);
    gpc = pcw & ((1 << mg) - 1);
    lowb = mg - n;
    hist = ghist & ((1 << n) - 1);
    gi = ((((gpc >> lowb) ^ hist) << lowb) | (gpc & ((1 << lowb) - 1))) & 12'hfff;
    ci = pcw & ((1 << mk) - 1);
    hit = 1; pred = 0; use_g = 0;
    if (btb_on) hit = btb_access(pc);
    if (hit) begin
      if (mode == MODE_GSHARE) begin
        use_g = 1;
        pred = gsh_ctr[gi] >= 2;
        gsh_ctr[gi] = step_ctr(gsh_ctr[gi], taken);
      end else if (mode == MODE_HYBRID) begin
        pb = bim_ctr[bi] >= 2;
        pg = gsh_ctr[gi] >= 2;
        rb = pb == taken;
        rg = pg == taken;
        use_g = cho_ctr[ci] >= 2;
        if (use_g) begin
          pred = pg;
          gsh_ctr[gi] = step_ctr(gsh_ctr[gi], taken);
        end else begin
          pred = pb;
          bim_ctr[bi] = step_ctr(bim_ctr[bi], taken);
        end
        if (rg && !rb) cho_ctr[ci] = step_ctr(cho_ctr[ci], 1);
        else if (rb && !rg) cho_ctr[ci] = step_ctr(cho_ctr[ci], 0);
      end else begin
        pred = bim_ctr[bi] >= 2;
        bim_ctr[bi] = step_ctr(bim_ctr[bi], taken);
      end
      if ((mode == MODE_GSHARE || mode == MODE_HYBRID) && n > 0)
        ghist = 12'((hist >> 1) | (int'(taken) << (n - 1)));
    end
    r.pred = pred;
    r.mispred = pred != taken;
    r.hit = hit;
    r.use_g = use_g;
    pending = {pending, r};
  endfunction

  function void check_result(res_t got);
    res_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %b", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.pred !== exp_r.pred)
      $display("%0t: predicted_taken expected %b actual %b", $time, exp_r.pred, got.pred);
    if (got.mispred !== exp_r.mispred)
      $display("%0t: mispredicted expected %b actual %b", $time, exp_r.mispred, got.mispred);
    if (got.hit !== exp_r.hit)
      $display("%0t: btb_hit expected %b actual %b", $time, exp_r.hit, got.hit);
    if (got.use_g !== exp_r.use_g)
      $display("%0t: chose_gshare expected %b actual %b", $time, exp_r.use_g, got.use_g);
    if (got !== exp_r) errors++;
  endfunction
endclass

module tb_hybrid_branch_predictor_btb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_branch_pc = '0;
  logic        in_actual_taken = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_predicted_taken, out_mispredicted, out_btb_hit, out_chose_gshare;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_wdata = '0;

  branch_scoreboard sb = new();
  int idle_cycles = 0;
  bit timed_out = 0;
  logic [31:0] hot_pcs[16];

  hybrid_branch_predictor_btb uut (.*);

  always #2 clk = ~clk;

  // Sample results at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_predicted_taken, out_mispredicted, out_btb_hit, out_chose_gshare});
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 20000) timed_out = 1;
  end

  // Receiver stalls at random; some stretches run without stalls.
  initial begin
    int n;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (n != 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Valid stays up after acceptance until the next falling edge, where the
  // next item or an idle takes over.
  task automatic send_branch(logic [31:0] pc, bit taken, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_branch_pc <= pc;
    in_actual_taken <= taken;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_branch(pc, taken);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [31:0] pc;
    for (int i = 0; i < count; i++) begin
      // Mostly a small loop-like set of hot branches, with some noise.
      if ($urandom_range(0, 9) < 8) pc = hot_pcs[$urandom_range(0, 15)];
      else pc = $urandom();
      send_branch(pc, (pc[5] ^ pc[9]) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) != 0);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 16; i++) hot_pcs[i] = $urandom();
    repeat (11) @(negedge clk);
    rst_n <= 1;

    // Directed: field extremes at reset settings, then each mode.
    send_branch(32'h0000_0000, 1'b0, 1'b0);
    send_branch(32'hffff_ffff, 1'b1, 1'b0);
    send_branch(32'h0000_0000, 1'b1, 1'b0);
    send_branch(32'hffff_ffff, 1'b0, 1'b0);
    drain();
    write_cfg(REG_MODE, 4'(MODE_GSHARE));
    write_cfg(REG_HISTORY_BITS, 4'd15);
    for (int i = 0; i < 4; i++) send_branch(32'h0000_1000, i[0], 1'b0);
    drain();
    write_cfg(REG_MODE, 4'(MODE_HYBRID));
    write_cfg(REG_HISTORY_BITS, 4'd0);
    write_cfg(REG_CHOOSER_BITS, 4'd0);
    for (int i = 0; i < 5; i++) send_branch(32'h0000_2004, i < 3, 1'b0);
    drain();
    // unused mode code behaves as bimodal
    write_cfg(REG_MODE, 4'd3);
    write_cfg(REG_BIMODAL_BITS, 4'd0);
    send_branch(32'h8000_0004, 1'b1, 1'b0);
    drain();
    write_cfg(REG_BTB_ENABLE, 4'd1);
    write_cfg(REG_BTB_WAYS, 4'd0);
    write_cfg(REG_BTB_SET_BITS, 4'd15);
    for (int i = 0; i < 4; i++)
      send_branch(i[1] ? 32'h0000_4000 : 32'h0000_3000, 1'b1, 1'b0);
    drain();

    // Random phases over varied settings.
    for (int ph = 0; ph < 16; ph++) begin
      write_cfg(REG_MODE, 4'($urandom_range(0, 3)));
      write_cfg(REG_BIMODAL_BITS, (ph == 1) ? 4'd15 : 4'($urandom_range(0, 15)));
      write_cfg(REG_GSHARE_BITS, (ph == 2) ? 4'd1 : 4'($urandom_range(0, 15)));
      write_cfg(REG_HISTORY_BITS, (ph == 3) ? 4'd12 : 4'($urandom_range(0, 15)));
      write_cfg(REG_CHOOSER_BITS, (ph == 4) ? 4'd12 : 4'($urandom_range(0, 15)));
      write_cfg(REG_BTB_ENABLE, ((ph % 3) != 0) ? 4'd1 : 4'd0);
      write_cfg(REG_BTB_SET_BITS, (ph == 5) ? 4'd8 : 4'($urandom_range(0, 4)));
      write_cfg(REG_BTB_WAYS,
                (ph == 6) ? 4'd8 : (ph == 7) ? 4'd15 : 4'($urandom_range(0, 8)));
      random_phase(100);
    end

    drain();
    if (!timed_out && sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_hybrid_branch_predictor_btb passed");
    else
      $display("tb_hybrid_branch_predictor_btb failed");
    $finish;
  end

  // Watchdog exit.
  initial begin
    wait (timed_out);
    $display("tb_hybrid_branch_predictor_btb failed");
    $finish;
  end
endmodule
